FILE: rtl/sgtd_pkg.sv
// Shared types, constants, font ROM and helper functions of the scrolling glyph display.
package sgtd_pkg;

  localparam int MAX_CHARS_DEF  = 16;
  localparam int RIGHT_SLOT_DEF = 13;

  localparam int          CHAR_PITCH       = 4;
  localparam int          GLYPH_W          = 3;
  localparam int          NUM_ROWS         = 8;
  localparam int          MAX_WITH_PREVIEW = 3;
  localparam logic [2:0]  SLIDE_STEPS      = 3'd4;
  localparam logic [3:0]  LAST_COL         = 4'd15;
  localparam logic [5:0]  DIGIT_BASE       = 6'd26;
  localparam logic [5:0]  SPACE_GLYPH      = 6'd36;
  localparam logic [5:0]  UNKNOWN_GLYPH    = 6'd37;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_PREVIEW = 2'd1,
    OP_TICK    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_BLACK = 2'd0,
    REG_GREEN = 2'd1,
    REG_RED   = 2'd2
  } reg_index_t;

  // where a column's pixels come from
  typedef enum logic [1:0] {
    SRC_BLANK = 2'd0,
    SRC_MEM   = 2'd1,
    SRC_PREV  = 2'd2
  } src_t;

  typedef struct packed {
    logic [3:0] col;
    src_t       src;
    logic [1:0] k;
  } col_info_t;

  // 3x6 font, three columns per glyph, bit r is row r
  localparam logic [0:37][0:2][7:0] GLYPH_ROM = {
    {8'h3E, 8'h48, 8'h3E}, {8'h7E, 8'h52, 8'h2C}, {8'h3C, 8'h42, 8'h42},
    {8'h7E, 8'h42, 8'h3C}, {8'h7E, 8'h52, 8'h42}, {8'h7E, 8'h50, 8'h40},
    {8'h3C, 8'h4A, 8'h4E}, {8'h7E, 8'h10, 8'h7E}, {8'h42, 8'h7E, 8'h42},
    {8'h0C, 8'h02, 8'h7C}, {8'h7E, 8'h10, 8'h6E}, {8'h7E, 8'h02, 8'h02},
    {8'h7E, 8'h30, 8'h7E}, {8'h7E, 8'h40, 8'h7E}, {8'h3C, 8'h42, 8'h3C},
    {8'h7E, 8'h48, 8'h30}, {8'h3C, 8'h46, 8'h3E}, {8'h7E, 8'h48, 8'h36},
    {8'h22, 8'h52, 8'h4C}, {8'h40, 8'h7E, 8'h40}, {8'h7C, 8'h02, 8'h7E},
    {8'h7C, 8'h02, 8'h7C}, {8'h7E, 8'h0C, 8'h7E}, {8'h66, 8'h18, 8'h66},
    {8'h60, 8'h1E, 8'h60}, {8'h46, 8'h5A, 8'h62},
    {8'h3C, 8'h52, 8'h3C}, {8'h22, 8'h7E, 8'h02}, {8'h4E, 8'h52, 8'h22},
    {8'h42, 8'h52, 8'h3C}, {8'h70, 8'h10, 8'h7E}, {8'h72, 8'h52, 8'h4C},
    {8'h3C, 8'h52, 8'h4C}, {8'h40, 8'h5E, 8'h60}, {8'h2C, 8'h52, 8'h2C},
    {8'h32, 8'h4A, 8'h3C},
    {8'h00, 8'h00, 8'h00}, {8'h20, 8'h4A, 8'h30}
  };

  // map an ASCII code to its glyph number
  function automatic logic [5:0] glyph_of(input logic [7:0] c);
    logic [5:0] g;
    if (c >= 8'h41 && c <= 8'h5A) begin
      g = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      g = 6'(c - 8'h61);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      g = 6'(c - 8'h30) + DIGIT_BASE;
    end else if (c == 8'h20) begin
      g = SPACE_GLYPH;
    end else begin
      g = UNKNOWN_GLYPH;
    end
    return g;
  endfunction

  // one pixel column of a glyph; the gap column reads as empty
  function automatic logic [7:0] font_column(input logic [5:0] g, input logic [1:0] k);
    logic [7:0] bits;
    if (k == 2'd3 || g > UNKNOWN_GLYPH) begin
      bits = 8'h00;
    end else begin
      bits = GLYPH_ROM[g][k];
    end
    return bits;
  endfunction

endpackage

FILE: rtl/sgtd_mem.sv
// Character history memory: one write port, one registered read port.
module sgtd_mem #(
  parameter int DEPTH = sgtd_pkg::MAX_CHARS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read one entry, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sgtd_pix.sv
// Column renderer: glyph lookup, row colours and the output register.
module sgtd_pix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s1_valid,
  input  sgtd_pkg::col_info_t   s1_info,
  input  logic [15:0]           rdata,
  input  logic [7:0]            preview_code,
  input  logic [7:0]            black_colour,
  input  logic [7:0]            red_colour,
  output logic                  s1_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,   // column_index, row0_colour .. row7_colour, pad
  output logic                  m_tlast    // frame_end
);

  logic [7:0]  code;
  logic [7:0]  colour;
  logic [7:0]  bits;
  logic [63:0] rows;

  assign s1_ready = !m_tvalid || m_tready;

  // pick the source of this column
  always_comb begin
    code   = rdata[7:0];
    colour = rdata[15:8];
    bits   = 8'h00;
    case (s1_info.src)
      sgtd_pkg::SRC_MEM: begin
        bits = sgtd_pkg::font_column(sgtd_pkg::glyph_of(code), s1_info.k);
      end
      sgtd_pkg::SRC_PREV: begin
        code   = preview_code;
        colour = red_colour;
        bits   = sgtd_pkg::font_column(sgtd_pkg::glyph_of(code), s1_info.k);
      end
      default: begin
        bits = 8'h00;
      end
    endcase
    for (int r = 0; r < sgtd_pkg::NUM_ROWS; r++) begin
      rows[r*8 +: 8] = bits[r] ? colour : black_colour;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      m_tdata <= {4'b0, rows, s1_info.col};
      m_tlast <= (s1_info.col == sgtd_pkg::LAST_COL);
    end
  end

endmodule

FILE: rtl/scrolling_glyph_text_display.sv
// Top level of the scrolling glyph display: state, column sequencer and history memory.
//
//  channel  | direction | payload
//  s_*      | in        | s_tdata: opcode, char_code, char_colour, mark_count, preview_code
//  m_*      | out       | m_tdata: column_index, row0..row7 colours; m_tlast: frame_end
//  cfg_*    | in        | cfg_index selects black, green or red colour; cfg_data value
//
// A redrawing item gives 16 column transfers, one a cycle while the output does not
// stall, through a memory read stage and then render into the output register. The
// column sequencer sets the rate: the next item is taken once the last column has
// left the read stage. Items that do not redraw give no column transfers. Reset is
// synchronous and clears the history count, the slide and the preview. An output
// stall holds the read stage and the sequencer.
module scrolling_glyph_text_display #(
  parameter int MAX_CHARS         = sgtd_pkg::MAX_CHARS_DEF,
  parameter int RIGHT_SLOT_COLUMN = sgtd_pkg::RIGHT_SLOT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // opcode, char_code, char_colour, mark_count, preview_code, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // column_index, row0_colour .. row7_colour, pad
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_CHARS);
  localparam logic [CW-1:0] PREV_LIM = CW'(sgtd_pkg::MAX_WITH_PREVIEW);

  logic [7:0]    black_colour;
  logic [7:0]    red_colour;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          slide_active;
  logic [2:0]    slide_offset;
  logic [7:0]    preview_count;
  logic [7:0]    preview_code;
  logic          busy;
  logic [3:0]    col;
  logic          s1_valid;
  sgtd_pkg::col_info_t s1_info;

  logic          s_fire;
  logic [1:0]    op;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW:0]   wsum;
  logic          s1_ready;
  logic          s1_move;
  logic          issue;
  logic [AW-1:0] raddr;
  logic [AW:0]   rsum;
  logic [CW-1:0] n;
  logic [CW-1:0] rel;
  logic signed [6:0] right;
  logic signed [6:0] w;
  logic signed [6:0] wp3;
  logic signed [6:0] nw;
  logic [2:0]    j;
  logic [1:0]    k;
  logic          hit_mem;
  logic          hit_prev;
  logic [5:0]    col6;
  logic [15:0]   rdata;
  sgtd_pkg::col_info_t info;

  assign s_tready = !busy && !s1_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign op       = s_tdata[1:0];
  assign s1_move  = s1_valid && s1_ready;
  assign issue    = busy && (!s1_valid || s1_ready);

  // write address: append behind the newest, or overwrite the oldest when full
  always_comb begin
    wsum = (AW+1)'(head) + (AW+1)'(count);
    if (wsum >= (AW+1)'(MAX_CHARS)) begin
      wsum = wsum - (AW+1)'(MAX_CHARS);
    end
    waddr = (count == FULL) ? head : wsum[AW-1:0];
    we    = s_fire && (op == sgtd_pkg::OP_APPEND);
  end

  // locate the glyph column under the current screen column
  always_comb begin
    n = count;
    if (preview_count != 8'd0 && count > PREV_LIM) begin
      n = PREV_LIM;
    end
    if (preview_count != 8'd0) begin
      right = 7'(RIGHT_SLOT_COLUMN - sgtd_pkg::CHAR_PITCH);
    end else begin
      right = 7'(RIGHT_SLOT_COLUMN) - $signed({4'b0, slide_offset});
    end
    w    = right - $signed({3'b0, col});
    wp3  = w + 7'sd3;
    nw   = -w;
    j    = wp3[4:2];
    k    = nw[1:0];
    hit_mem = (w >= -7'sd3) && (k != 2'd3) && ((CW+3)'(j) < (CW+3)'(n));
    rel  = count - CW'(1) - CW'(j);
    rsum = (AW+1)'(head) + (AW+1)'(rel[AW-1:0]);
    if (rsum >= (AW+1)'(MAX_CHARS)) begin
      rsum = rsum - (AW+1)'(MAX_CHARS);
    end
    raddr = rsum[AW-1:0];
    col6  = {2'b0, col};
    hit_prev = (preview_count != 8'd0) && (col6 >= 6'(RIGHT_SLOT_COLUMN))
               && (col6 <= 6'(RIGHT_SLOT_COLUMN + sgtd_pkg::GLYPH_W - 1));
    info.col = col;
    if (hit_prev) begin
      info.src = sgtd_pkg::SRC_PREV;
      info.k   = 2'(col6 - 6'(RIGHT_SLOT_COLUMN));
    end else if (hit_mem) begin
      info.src = sgtd_pkg::SRC_MEM;
      info.k   = k;
    end else begin
      info.src = sgtd_pkg::SRC_BLANK;
      info.k   = k;
    end
  end

  // colour registers; green is accepted but not drawn with
  always_ff @(posedge clk) begin
    if (rst) begin
      black_colour <= 8'd0;
      red_colour   <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgtd_pkg::REG_BLACK: black_colour <= cfg_data;
        sgtd_pkg::REG_RED:   red_colour   <= cfg_data;
        default: ;
      endcase
    end
  end

  // display state and column sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      count         <= '0;
      slide_active  <= 1'b0;
      slide_offset  <= 3'd0;
      preview_count <= 8'd0;
      preview_code  <= 8'd0;
      busy          <= 1'b0;
      col           <= 4'd0;
      s1_valid      <= 1'b0;
    end else begin
      if (s_fire) begin
        col <= 4'd0;
        unique case (op)
          sgtd_pkg::OP_APPEND: begin
            if (count == FULL) begin
              head <= (head == AW'(MAX_CHARS - 1)) ? '0 : head + AW'(1);
            end else begin
              count <= count + CW'(1);
            end
            preview_count <= 8'd0;
            preview_code  <= 8'd0;
            slide_active  <= 1'b1;
            slide_offset  <= 3'd0;
            busy          <= 1'b1;
          end
          sgtd_pkg::OP_PREVIEW: begin
            preview_count <= s_tdata[25:18];
            preview_code  <= s_tdata[33:26];
            slide_active  <= 1'b0;
            slide_offset  <= 3'd0;
            busy          <= 1'b1;
          end
          sgtd_pkg::OP_TICK: begin
            if (slide_active) begin
              slide_offset <= slide_offset + 3'd1;
              if (slide_offset + 3'd1 == sgtd_pkg::SLIDE_STEPS) begin
                slide_active <= 1'b0;
              end
              busy <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // advance one column into the read stage
      if (issue) begin
        s1_valid <= 1'b1;
        col      <= col + 4'd1;
        if (col == sgtd_pkg::LAST_COL) begin
          busy <= 1'b0;
        end
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_info <= info;
    end
  end

  sgtd_mem #(
    .DEPTH (MAX_CHARS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({s_tdata[17:10], s_tdata[9:2]}),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  sgtd_pix u_pix (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_info      (s1_info),
    .rdata        (rdata),
    .preview_code (preview_code),
    .black_colour (black_colour),
    .red_colour   (red_colour),
    .s1_ready     (s1_ready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

  // history never grows past its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count <= FULL) && (32'(head) < MAX_CHARS))
    else $error("history count or head out of range");

  // the last column ends the frame sequencer
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    issue && (col == sgtd_pkg::LAST_COL) |=> !busy)
    else $error("sequencer kept running after the last column");

  // a stalled read stage keeps its column
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_info) && $stable(rdata))
    else $error("read stage changed while stalled");

  // no new item while a frame is still in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (busy || s1_valid) |-> !s_fire)
    else $error("item accepted during a redraw");

endmodule
